[sv/mctb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mctb_pkg
// Shared codes and bus types of the countdown timer bank and its slot cells.
// ----------------------------------------------------------------------------
package mctb_pkg;

    // Command codes carried by the action field
    localparam logic [3:0] ACT_TICK     = 4'd0;
    localparam logic [3:0] ACT_CREATE   = 4'd1;
    localparam logic [3:0] ACT_DELETE   = 4'd2;
    localparam logic [3:0] ACT_START    = 4'd3;
    localparam logic [3:0] ACT_PAUSE    = 4'd4;
    localparam logic [3:0] ACT_RESUME   = 4'd5;
    localparam logic [3:0] ACT_SET_PER  = 4'd6;
    localparam logic [3:0] ACT_SET_RND  = 4'd7;
    localparam logic [3:0] ACT_READ_RND = 4'd8;

    // Result codes carried by event_res
    localparam logic [1:0] EV_EXPIRY  = 2'd0;
    localparam logic [1:0] EV_CREATED = 2'd1;
    localparam logic [1:0] EV_FULL    = 2'd2;
    localparam logic [1:0] EV_ROUNDS  = 2'd3;

    // Expiries reported per tick at most
    localparam int MAX_OUT = 8;
    localparam int REP_W   = $clog2(MAX_OUT + 1);

    // Sweep controls broadcast to every cell; only the token holder acts
    typedef struct packed {
        logic        tick_p0;   // subtract elapsed ticks
        logic        tick_p1;   // expire, reload, free a deleted slot
        logic        claim;     // initialize a free slot for create
        logic [23:0] elapsed;
    } sweep_t;

    // Addressed command broadcast to every cell
    typedef struct packed {
        logic        en;
        logic [3:0]  action;
        logic [2:0]  slot;
        logic [30:0] period;
        logic        periodic;
        logic [31:0] rounds;
    } cmd_t;

    // Status returned by each cell
    typedef struct packed {
        logic        tok;        // cell holds the sweep token
        logic        expire;     // token holder is due to expire
        logic        free;       // token holder is a free slot
        logic [31:0] inc_rounds; // round count after an expiry
        logic [31:0] rd_rounds;  // round count of the addressed live slot, else 0
    } cell_out_t;

endpackage
`default_nettype wire

[sv/mctb_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mctb_cell
// One timer slot: count, period, rounds and flags, plus one stage of the
// token chain that walks a sweep across the bank.
// ----------------------------------------------------------------------------
module mctb_cell
    import mctb_pkg::*;
#(
    parameter int CELL_ID    = 0,
    parameter int COUNT_BITS = 32
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire sweep_t    sweep,
    input  wire cmd_t      cmd,
    input  wire logic      shift,
    input  wire logic      tok_in,
    output cell_out_t      status
);

    localparam int XW = COUNT_BITS + 33;

    localparam logic signed [COUNT_BITS-1:0] CMIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
    localparam logic signed [COUNT_BITS-1:0] CMAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [XW-1:0] CMIN_X = {{(XW-COUNT_BITS){1'b1}}, CMIN};
    localparam logic signed [XW-1:0] CMAX_X = {{(XW-COUNT_BITS){1'b0}}, CMAX};

    logic signed [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [30:0]                  period_reg, period_next;
    logic [31:0]                  rounds_reg, rounds_next;
    logic                         pause_reg, pause_next;
    logic                         repeat_reg, repeat_next;
    logic                         valid_reg, valid_next;
    logic                         remove_reg, remove_next;
    logic                         tok_reg, tok_next;

    logic signed [XW-1:0] cnt_x, elapsed_x, period_x, new_period_x, diff_x, sum_x;
    logic signed [COUNT_BITS-1:0] sat_sub, reload, start_cnt;
    logic cnt_pos, cnt_le0, match, running;

    assign cnt_x        = {{(XW-COUNT_BITS){cnt_reg[COUNT_BITS-1]}}, cnt_reg};
    assign elapsed_x    = {{(XW-24){1'b0}}, sweep.elapsed};
    assign period_x     = {{(XW-31){1'b0}}, period_reg};
    assign new_period_x = {{(XW-31){1'b0}}, cmd.period};
    assign diff_x       = cnt_x - elapsed_x;
    assign sum_x        = cnt_x + period_x;

    // Floor at the minimum on decrement, ceiling at the maximum on load
    assign sat_sub   = (diff_x < CMIN_X) ? CMIN : diff_x[COUNT_BITS-1:0];
    assign reload    = (sum_x > CMAX_X) ? CMAX : sum_x[COUNT_BITS-1:0];
    assign start_cnt = (new_period_x > CMAX_X) ? CMAX : new_period_x[COUNT_BITS-1:0];

    assign cnt_pos = !cnt_reg[COUNT_BITS-1] && (|cnt_reg);
    assign cnt_le0 = cnt_reg[COUNT_BITS-1] || !(|cnt_reg);
    assign match   = (int'(cmd.slot) == CELL_ID);
    assign running = valid_reg && !pause_reg;

    always_comb
    begin
        cnt_next    = cnt_reg;
        period_next = period_reg;
        rounds_next = rounds_reg;
        pause_next  = pause_reg;
        repeat_next = repeat_reg;
        valid_next  = valid_reg;
        remove_next = remove_reg;
        tok_next    = shift ? tok_in : tok_reg;

        if (sweep.tick_p0 && tok_reg && running && cnt_pos)
        begin
            cnt_next = sat_sub;
        end

        if (sweep.tick_p1 && tok_reg)
        begin
            if (running && cnt_le0)
            begin
                rounds_next = rounds_reg + 32'd1;
                if (repeat_reg)
                begin
                    cnt_next = reload;
                end
                else
                begin
                    cnt_next   = '0;
                    pause_next = 1'b1;
                end
            end
            // Drop a deleted slot once it has taken its last step
            if (valid_reg && remove_reg)
            begin
                valid_next  = 1'b0;
                remove_next = 1'b0;
            end
        end

        if (sweep.claim && tok_reg)
        begin
            cnt_next    = '0;
            period_next = '0;
            rounds_next = '0;
            pause_next  = 1'b0;
            repeat_next = 1'b1;
            remove_next = 1'b0;
            valid_next  = 1'b1;
        end

        if (cmd.en && match && valid_reg)
        begin
            unique case (cmd.action)
                ACT_DELETE:
                begin
                    remove_next = 1'b1;
                end
                ACT_START:
                begin
                    period_next = cmd.period;
                    cnt_next    = start_cnt;
                    rounds_next = '0;
                    pause_next  = 1'b0;
                    remove_next = 1'b0;
                end
                ACT_PAUSE:
                begin
                    pause_next = 1'b1;
                end
                ACT_RESUME:
                begin
                    pause_next = 1'b0;
                end
                ACT_SET_PER:
                begin
                    repeat_next = cmd.periodic;
                end
                ACT_SET_RND:
                begin
                    rounds_next = cmd.rounds;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            period_reg <= '0;
            rounds_reg <= '0;
            pause_reg  <= 1'b0;
            repeat_reg <= 1'b1;
            valid_reg  <= 1'b0;
            remove_reg <= 1'b0;
            tok_reg    <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            period_reg <= period_next;
            rounds_reg <= rounds_next;
            pause_reg  <= pause_next;
            repeat_reg <= repeat_next;
            valid_reg  <= valid_next;
            remove_reg <= remove_next;
            tok_reg    <= tok_next;
        end
    end

    assign status.tok        = tok_reg;
    assign status.expire     = tok_reg && running && cnt_le0;
    assign status.free       = tok_reg && !valid_reg;
    assign status.inc_rounds = tok_reg ? (rounds_reg + 32'd1) : '0;
    assign status.rd_rounds  = (match && valid_reg) ? rounds_reg : '0;

endmodule
`default_nettype wire

[sv/multi_channel_countdown_timer_bank.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_countdown_timer_bank
// Bank of countdown timer slots built as a row of slot cells. A sweep token
// walks the row for tick and create; addressed commands act directly, without a sweep.
// ----------------------------------------------------------------------------
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------------------------
//  cmd     | cmd_valid | cmd_stall | action slot elapsed period_ticks periodic
//          |           |           | rounds_value
//  evt     | evt_valid | evt_stall | event_res slot_id round_count last
//
//  Tick and create run a sweep: the token visits each cell in turn in two phases
//  (tick: subtract, then expire and reload; create: claim a free slot). The token
//  holds for every cycle in which an expiry finds the pending stage full and the
//  output register stalled. The next command is taken once the bank is idle again
//  and any result left by the sweep has moved on to the output register.
//  Delete, start, pause, resume, set periodic and set rounds act directly on the
//  addressed cell; read rounds yields one result through the pending stage.
//  Reset puts every slot in the free state; no clearing pass is needed.
//  The command side is stalled during a sweep and while a result is still
//  held in the pending stage; the result register holds under evt_stall.
// ----------------------------------------------------------------------------
module multi_channel_countdown_timer_bank
    import mctb_pkg::*;
#(
    parameter int NUM_SLOTS  = 8,
    parameter int COUNT_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cmd_valid,
    output logic             cmd_stall,
    input  wire logic [3:0]  action,
    input  wire logic [2:0]  slot,
    input  wire logic [23:0] elapsed,
    input  wire logic [30:0] period_ticks,
    input  wire logic        periodic,
    input  wire logic [31:0] rounds_value,

    output logic             evt_valid,
    input  wire logic        evt_stall,
    output logic [1:0]       event_res,
    output logic [2:0]       slot_id,
    output logic [31:0]      round_count,
    output logic             last
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_SWEEP = 1'b1;

    // Controller state
    logic             state_reg, state_next;
    logic             is_tick_reg, is_tick_next;   // sweep kind: tick or create
    logic             phase_reg, phase_next;
    logic             found_reg, found_next;
    logic [REP_W-1:0] rep_reg, rep_next;
    logic [23:0]      elapsed_reg, elapsed_next;

    // Pending result stage: holds one result until its last flag is known
    logic        pend_valid_reg, pend_valid_next;
    logic        pend_last_reg, pend_last_next;
    logic [1:0]  pend_ev_reg, pend_ev_next;
    logic [2:0]  pend_id_reg, pend_id_next;
    logic [31:0] pend_rc_reg, pend_rc_next;

    // Output register
    logic        evt_valid_reg, evt_valid_next;
    logic        evt_last_reg, evt_last_next;
    logic [1:0]  evt_ev_reg, evt_ev_next;
    logic [2:0]  evt_id_reg, evt_id_next;
    logic [31:0] evt_rc_reg, evt_rc_next;

    cell_out_t            cell_st [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] tok_vec;
    sweep_t               sweep;
    cmd_t                 cmd;

    logic        cmd_acc, start_sweep, out_free, in_sweep_p1;
    logic        sel_exp, sel_free, hit, blocked, adv, sweep_end, shift, xfer;
    logic [2:0]  sel_id;
    logic [31:0] sel_inc, rd_rounds;
    logic [1:0]  hit_ev;
    logic [31:0] hit_rc;

    assign cmd_stall   = (state_reg != ST_IDLE) || pend_valid_reg;
    assign cmd_acc     = cmd_valid && !cmd_stall;
    assign start_sweep = cmd_acc && ((action == ACT_TICK) || (action == ACT_CREATE));
    assign out_free    = !evt_valid_reg || !evt_stall;

    // Collect the token holder's status and the addressed slot's round count
    always_comb
    begin
        sel_exp   = 1'b0;
        sel_free  = 1'b0;
        sel_id    = '0;
        sel_inc   = '0;
        rd_rounds = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            tok_vec[i] = cell_st[i].tok;
            sel_exp    = sel_exp | cell_st[i].expire;
            sel_free   = sel_free | cell_st[i].free;
            sel_inc    = sel_inc | cell_st[i].inc_rounds;
            rd_rounds  = rd_rounds | cell_st[i].rd_rounds;
            if (cell_st[i].tok)
            begin
                sel_id = 3'(i);
            end
        end
    end

    // Second half of each cell visit: a result may be produced here
    assign in_sweep_p1 = (state_reg == ST_SWEEP) && phase_reg;
    assign hit = in_sweep_p1 && (is_tick_reg ? (sel_exp && (rep_reg != REP_W'(MAX_OUT)))
                                             : (sel_free && !found_reg));
    assign hit_ev = is_tick_reg ? EV_EXPIRY : EV_CREATED;
    assign hit_rc = is_tick_reg ? sel_inc : '0;

    // Hold the token when a new result would push the pending one into a full register
    assign blocked   = hit && pend_valid_reg && !out_free;
    assign adv       = !blocked;
    assign sweep_end = in_sweep_p1 && adv && tok_vec[NUM_SLOTS-1];
    assign shift     = ((state_reg == ST_IDLE) && start_sweep) || (in_sweep_p1 && adv);
    assign xfer      = out_free && pend_valid_reg && (pend_last_reg || (hit && adv));

    assign sweep.tick_p0 = (state_reg == ST_SWEEP) && is_tick_reg && !phase_reg;
    assign sweep.tick_p1 = in_sweep_p1 && is_tick_reg && adv;
    assign sweep.claim   = in_sweep_p1 && !is_tick_reg && sel_free && !found_reg;
    assign sweep.elapsed = elapsed_reg;

    assign cmd.en       = cmd_acc && (action >= ACT_DELETE) && (action <= ACT_READ_RND);
    assign cmd.action   = action;
    assign cmd.slot     = slot;
    assign cmd.period   = period_ticks;
    assign cmd.periodic = periodic;
    assign cmd.rounds   = rounds_value;

    for (genvar g = 0; g < NUM_SLOTS; g++)
    begin : g_cell
        logic tok_feed;
        if (g == 0)
        begin : g_head
            assign tok_feed = (state_reg == ST_IDLE);
        end
        else
        begin : g_body
            assign tok_feed = cell_st[g-1].tok;
        end

        mctb_cell #(
            .CELL_ID    (g),
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .sweep  (sweep),
            .cmd    (cmd),
            .shift  (shift),
            .tok_in (tok_feed),
            .status (cell_st[g])
        );
    end

    // Sequencing of sweeps
    always_comb
    begin
        state_next   = state_reg;
        is_tick_next = is_tick_reg;
        phase_next   = phase_reg;
        found_next   = found_reg;
        rep_next     = rep_reg;
        elapsed_next = elapsed_reg;

        if (start_sweep)
        begin
            state_next   = ST_SWEEP;
            is_tick_next = (action == ACT_TICK);
            phase_next   = 1'b0;
            found_next   = 1'b0;
            rep_next     = '0;
            elapsed_next = elapsed;
        end
        else if (state_reg == ST_SWEEP)
        begin
            if (!phase_reg)
            begin
                phase_next = 1'b1;
            end
            else if (adv)
            begin
                phase_next = 1'b0;
                if (hit && is_tick_reg)
                begin
                    rep_next = rep_reg + REP_W'(1);
                end
                if (hit && !is_tick_reg)
                begin
                    found_next = 1'b1;
                end
                if (sweep_end)
                begin
                    state_next = ST_IDLE;
                end
            end
        end
    end

    // Pending stage and output register
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_last_next  = pend_last_reg;
        pend_ev_next    = pend_ev_reg;
        pend_id_next    = pend_id_reg;
        pend_rc_next    = pend_rc_reg;

        evt_valid_next = evt_valid_reg;
        evt_last_next  = evt_last_reg;
        evt_ev_next    = evt_ev_reg;
        evt_id_next    = evt_id_reg;
        evt_rc_next    = evt_rc_reg;

        if (xfer)
        begin
            evt_valid_next = 1'b1;
            evt_last_next  = pend_last_reg;
            evt_ev_next    = pend_ev_reg;
            evt_id_next    = pend_id_reg;
            evt_rc_next    = pend_rc_reg;
        end
        else if (evt_valid_reg && !evt_stall)
        begin
            evt_valid_next = 1'b0;
        end

        priority if (cmd_acc && (action == ACT_READ_RND))
        begin
            pend_valid_next = 1'b1;
            pend_last_next  = 1'b1;
            pend_ev_next    = EV_ROUNDS;
            pend_id_next    = slot;
            pend_rc_next    = rd_rounds;
        end
        else if (hit && adv)
        begin
            pend_valid_next = 1'b1;
            pend_last_next  = sweep_end;
            pend_ev_next    = hit_ev;
            pend_id_next    = sel_id;
            pend_rc_next    = hit_rc;
        end
        else if (sweep_end && pend_valid_reg)
        begin
            pend_last_next = 1'b1;
        end
        else if (sweep_end && !is_tick_reg)
        begin
            // No free slot seen during the whole create sweep
            pend_valid_next = 1'b1;
            pend_last_next  = 1'b1;
            pend_ev_next    = EV_FULL;
            pend_id_next    = '0;
            pend_rc_next    = '0;
        end
        else if (xfer)
        begin
            pend_valid_next = 1'b0;
        end
        else
        begin
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            is_tick_reg    <= 1'b0;
            phase_reg      <= 1'b0;
            found_reg      <= 1'b0;
            rep_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
            evt_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            is_tick_reg    <= is_tick_next;
            phase_reg      <= phase_next;
            found_reg      <= found_next;
            rep_reg        <= rep_next;
            pend_valid_reg <= pend_valid_next;
            pend_last_reg  <= pend_last_next;
            evt_valid_reg  <= evt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        elapsed_reg  <= elapsed_next;
        pend_ev_reg  <= pend_ev_next;
        pend_id_reg  <= pend_id_next;
        pend_rc_reg  <= pend_rc_next;
        evt_last_reg <= evt_last_next;
        evt_ev_reg   <= evt_ev_next;
        evt_id_reg   <= evt_id_next;
        evt_rc_reg   <= evt_rc_next;
    end

    assign evt_valid   = evt_valid_reg;
    assign event_res   = evt_ev_reg;
    assign slot_id     = evt_id_reg;
    assign round_count = evt_rc_reg;
    assign last        = evt_last_reg;

    // At most one cell carries the sweep token
    a_tok_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vec))
        else $error("sweep token held by more than one cell");

    // No token is left in the row once the bank is idle
    a_tok_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (tok_vec == '0))
        else $error("token left in the row while idle");

    // During a sweep the pending result is never marked final
    a_pend_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SWEEP) && pend_valid_reg) |-> !pend_last_reg)
        else $error("pending result marked last before the sweep ended");

    // A sweep that ends leaves a final result or nothing, never an open one
    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_end |=> (!pend_valid_reg || pend_last_reg))
        else $error("sweep ended with an open pending result");

endmodule
`default_nettype wire
